@@ sv/command_line_tokenizer_core_defines.svh @@
// Assertion macros shared by the tokenizer modules
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLT_ASSERT(lbl, cond, msg)
`define CLT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/clt_pkg.sv @@
// Types and constants shared by the command-line tokenizer modules
package clt_pkg;

  localparam logic [7:0] CH_EOL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_SINGLE = 2'd1,
    QK_DOUBLE = 2'd2
  } clt_quote_t;

  typedef struct packed {
    logic [7:0] arg_byte;
    logic       byte_valid;
    logic [2:0] arg_index;
    logic       arg_start;
    logic       arg_end;
    logic       line_done;
    logic [3:0] arg_count;
  } clt_res_t;

  typedef struct packed {
    logic     valid;
    clt_res_t res;
  } clt_push_t;

endpackage

@@ sv/clt_front.sv @@
// Front end: accept and classify line bytes, track argument state, build results
`include "command_line_tokenizer_core_defines.svh"
module clt_front import clt_pkg::*; #(
  parameter int MAX_ARGS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_char,
  input  logic       q_full,
  output clt_push_t  push
);

  localparam int CW = $clog2(MAX_ARGS + 1);
  localparam int EW = (CW < 4) ? 4 : CW;

  logic          in_arg_r, in_arg_nxt;
  clt_quote_t    qk_r, qk_nxt;
  logic          esc_r, esc_nxt;
  logic [CW-1:0] cc_r, cc_nxt;
  logic [CW-1:0] cc_inc;
  logic [EW-1:0] cc_ext, cc_inc_ext;
  logic          in_acc;
  clt_quote_t    kind;
  clt_res_t      res;
  logic          has_res;

  assign in_tready  = !q_full;
  assign in_acc     = in_tvalid && in_tready;
  assign cc_inc     = cc_r + CW'(1);
  assign cc_ext     = EW'(cc_r);
  assign cc_inc_ext = EW'(cc_inc);

  always_comb begin
    kind = QK_NONE;
    if (in_char == CH_SQUOTE) begin
      kind = QK_SINGLE;
    end else if (in_char == CH_DQUOTE) begin
      kind = QK_DOUBLE;
    end
  end

  always_comb begin
    in_arg_nxt = in_arg_r;
    qk_nxt     = qk_r;
    esc_nxt    = esc_r;
    cc_nxt     = cc_r;
    has_res    = 1'b0;
    res        = '0;
    if (in_char == CH_EOL) begin
      has_res       = 1'b1;
      res.line_done = 1'b1;
      res.arg_end   = in_arg_r;
      res.arg_index = in_arg_r ? cc_ext[2:0] : 3'd0;
      res.arg_count = in_arg_r ? cc_inc_ext[3:0] : cc_ext[3:0];
      in_arg_nxt    = 1'b0;
      qk_nxt        = QK_NONE;
      esc_nxt       = 1'b0;
      cc_nxt        = '0;
    end else if (cc_r >= CW'(MAX_ARGS)) begin
      has_res = 1'b0;
    end else if (!esc_r && in_char == CH_BACKSLASH) begin
      esc_nxt = 1'b1;
    end else if (!esc_r && kind != QK_NONE && (qk_r == QK_NONE || qk_r == kind)) begin
      qk_nxt = (qk_r == QK_NONE) ? kind : QK_NONE;
    end else if (!esc_r && qk_r == QK_NONE &&
                 (in_char == CH_SPACE || in_char == CH_TAB)) begin
      if (in_arg_r) begin
        has_res       = 1'b1;
        res.arg_end   = 1'b1;
        res.arg_index = cc_ext[2:0];
        res.arg_count = cc_inc_ext[3:0];
        in_arg_nxt    = 1'b0;
        cc_nxt        = cc_inc;
      end
    end else begin
      has_res        = 1'b1;
      res.arg_byte   = in_char;
      res.byte_valid = 1'b1;
      res.arg_index  = cc_ext[2:0];
      res.arg_start  = !in_arg_r;
      res.arg_count  = cc_ext[3:0];
      in_arg_nxt     = 1'b1;
      esc_nxt        = 1'b0;
    end
  end

  assign push.valid = in_acc && has_res;
  assign push.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_arg_r <= 1'b0;
      qk_r     <= QK_NONE;
      esc_r    <= 1'b0;
      cc_r     <= '0;
    end else if (in_acc) begin
      in_arg_r <= in_arg_nxt;
      qk_r     <= qk_nxt;
      esc_r    <= esc_nxt;
      cc_r     <= cc_nxt;
    end
  end

  `CLT_ASSERT(a_count_bound, cc_r <= CW'(MAX_ARGS), "closed count above limit")
  `CLT_ASSERT(a_open_below_limit, !in_arg_r || cc_r < CW'(MAX_ARGS), "open arg at limit")
  `CLT_ASSERT_NEXT(a_eol_clear, in_acc && in_char == CH_EOL,
    cc_r == '0 && !in_arg_r && !esc_r && qk_r == QK_NONE, "state not cleared at eol")

endmodule

@@ sv/clt_queue.sv @@
// Two-entry result queue between the front end and the output stage
`include "command_line_tokenizer_core_defines.svh"
module clt_queue import clt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  clt_push_t push,
  output logic      full,
  output logic      q_valid,
  output clt_res_t  q_res,
  input  logic      pop
);

  clt_res_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCW'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_res   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + QCW'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `CLT_ASSERT(a_q_bound, cnt_r <= QCW'(QDEPTH), "queue count overflow")
  `CLT_ASSERT(a_q_no_underrun, !(pop && cnt_r == '0), "pop from empty queue")
  `CLT_ASSERT_NEXT(a_q_grow, push.valid && !pop, cnt_r == $past(cnt_r) + QCW'(1),
    "queue count did not advance")

endmodule

@@ sv/clt_back.sv @@
// Back end: output register that takes results from the queue and packs the stream
module clt_back import clt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  clt_res_t    q_res,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic     vld_r;
  clt_res_t res_r;

  assign pop = q_valid && (!vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || out_tready) begin
      vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= q_res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {7'd0, res_r.arg_count, res_r.arg_end, res_r.arg_start,
                       res_r.arg_index, res_r.arg_byte};
  assign out_tuser  = res_r.byte_valid;
  assign out_tlast  = res_r.line_done;

endmodule

@@ sv/command_line_tokenizer_core.sv @@
// Results go into the two-entry queue, then into the output register behind out_tvalid.
// Throughput: one byte per cycle; in_tready drops only while the two-entry queue is full.
// The per-byte decision is a combinational classification against the argument state.
// Unescaped backslashes, group quotes and blanks outside an argument only update state.
// Reset (rst_n low, synchronous) clears argument state, queue and output valid.
module command_line_tokenizer_core import clt_pkg::*; #(
  parameter int MAX_ARGS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [7:0] arg_byte, [10:8] arg_index, [11] arg_start,
                                   // [12] arg_end, [16:13] arg_count, [23:17] zero
  output logic        out_tuser,   // [0] byte_valid
  output logic        out_tlast    // line_done
);

  clt_push_t push;
  logic      q_full;
  logic      q_valid;
  clt_res_t  q_res;
  logic      pop;

  clt_front #(
    .MAX_ARGS(MAX_ARGS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_char  (in_tdata),
    .q_full   (q_full),
    .push     (push)
  );

  clt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (q_full),
    .q_valid(q_valid),
    .q_res  (q_res),
    .pop    (pop)
  );

  clt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_res     (q_res),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

@@ dv/tb.sv @@
// Testbench for command_line_tokenizer_core: byte stimulus, tokenizer prediction, result check
`timescale 1ns / 1ps

module tb;
  import clt_pkg::*;

  localparam int MAX_ARGS = 8;
  localparam int SETTLE = 8;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  bit         steady = 1'b0;
  int         errors = 0;
  int         bytes_sent = 0;
  int         lines_sent = 0;
  int         results_seen = 0;
  int         quiet = 0;
  clt_res_t   pending_results[$];

  bit         arg_open;
  clt_quote_t group_kind;
  bit         escaped;
  int         args_closed;

  command_line_tokenizer_core #(.MAX_ARGS(MAX_ARGS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic void clear_line();
    arg_open = 1'b0;
    group_kind = QK_NONE;
    escaped = 1'b0;
    args_closed = 0;
  endfunction

  function automatic void put_byte(input logic [7:0] c, output clt_res_t r);
    r.arg_byte = c;
    r.byte_valid = 1'b1;
    r.arg_index = args_closed[2:0];
    r.arg_start = !arg_open;
    r.arg_count = args_closed[3:0];
    arg_open = 1'b1;
  endfunction

  function automatic bit tokenize_char(input logic [7:0] c, output clt_res_t r);
    clt_quote_t kind;
    r = '0;
    kind = QK_NONE;
    if (c == CH_EOL) begin
      if (arg_open) begin
        r.arg_index = args_closed[2:0];
        r.arg_end = 1'b1;
        args_closed++;
      end
      r.line_done = 1'b1;
      r.arg_count = args_closed[3:0];
      clear_line();
      return 1'b1;
    end
    if (args_closed >= MAX_ARGS) return 1'b0;
    if (escaped) begin
      escaped = 1'b0;
      put_byte(c, r);
      return 1'b1;
    end
    if (c == CH_BACKSLASH) begin
      escaped = 1'b1;
      return 1'b0;
    end
    if (c == CH_SQUOTE) kind = QK_SINGLE;
    else if (c == CH_DQUOTE) kind = QK_DOUBLE;
    if (kind != QK_NONE && (group_kind == QK_NONE || group_kind == kind)) begin
      group_kind = (group_kind == QK_NONE) ? kind : QK_NONE;
      return 1'b0;
    end
    if (group_kind == QK_NONE && (c == CH_SPACE || c == CH_TAB)) begin
      if (!arg_open) return 1'b0;
      r.arg_index = args_closed[2:0];
      r.arg_end = 1'b1;
      arg_open = 1'b0;
      args_closed++;
      r.arg_count = args_closed[3:0];
      return 1'b1;
    end
    put_byte(c, r);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int want, input int got);
    errors++;
    $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h", $realtime, results_seen,
             field, want, got);
  endtask

  task automatic send_char(input logic [7:0] c);
    clt_res_t r;
    in_tvalid <= 1'b1;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (tokenize_char(c, r)) pending_results.push_back(r);
    if (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 35);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_SQUOTE || c == CH_DQUOTE ||
           c == CH_BACKSLASH);
    return c;
  endfunction

  function automatic logic [7:0] group_char(input logic [7:0] q);
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
      default: return plain_char();
    endcase
  endfunction

  task automatic send_blank();
    send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  task automatic send_line(input int n_args, input int broken_pct);
    logic [7:0] q;
    for (int a = 0; a < n_args; a++) begin
      if (a > 0 || $urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2)) send_blank();
      end
      repeat ($urandom_range(1, 4)) begin
        q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        case ($urandom_range(5))
          2: begin
            send_char(q);
            repeat ($urandom_range(0, 4)) send_char(group_char(q));
            send_char(q);
          end
          3: begin
            send_char(CH_BACKSLASH);
            send_char(8'($urandom_range(1, 255)));
          end
          4: begin
            send_char(q);
            send_char(q);
          end
          default: send_char(plain_char());
        endcase
      end
    end
    if ($urandom_range(99) < broken_pct) begin
      if ($urandom_range(1)) send_char($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
      if ($urandom_range(1)) send_char(plain_char());
      if ($urandom_range(1)) send_blank();
      if ($urandom_range(1)) send_char(CH_BACKSLASH);
    end else if ($urandom_range(3) == 0) begin
      send_blank();
    end
    send_char(CH_EOL);
    lines_sent++;
  endtask

  task automatic test_directed();
    logic [7:0] bytes[$];
    bytes = '{CH_EOL,
              CH_SPACE, 8'h01, CH_TAB, CH_DQUOTE, CH_SPACE, CH_SQUOTE, 8'hFF, CH_DQUOTE,
              CH_SPACE, CH_SQUOTE, CH_SQUOTE, CH_SPACE, CH_BACKSLASH, CH_DQUOTE, CH_EOL,
              CH_SQUOTE, CH_BACKSLASH, CH_EOL};
    foreach (bytes[i]) send_char(bytes[i]);
    lines_sent += 3;
    wait_drained();
  endtask

  task automatic test_quoted_lines();
    bit paused = 1'b0;
    while (bytes_sent < 150) begin
      send_line($urandom_range(0, 6), 20);
      if (!paused && bytes_sent > 90) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  task automatic test_arg_limit();
    repeat (4) send_line($urandom_range(MAX_ARGS + 1, MAX_ARGS + 3), 10);
    send_line(MAX_ARGS, 0);
  endtask

  task automatic test_back_to_back();
    int stop;
    wait_drained();
    steady = 1'b1;
    stop = bytes_sent + 90;
    while (bytes_sent < stop) send_line($urandom_range(1, 5), 15);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_noise();
    logic [7:0] c;
    repeat (100) begin
      case ($urandom_range(7))
        0: c = CH_EOL;
        1: c = CH_BACKSLASH;
        2: c = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
        3: c = $urandom_range(1) ? CH_SPACE : CH_TAB;
        default: c = 8'($urandom_range(0, 255));
      endcase
      if (c == CH_EOL) lines_sent++;
      send_char(c);
    end
    send_char(CH_EOL);
    lines_sent++;
  endtask

  always @(posedge clk) begin
    out_tready <= steady || $urandom_range(99) >= 35;
  end

  always @(posedge clk) begin : check_results
    clt_res_t want;
    clt_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.arg_byte = out_tdata[7:0];
      got.byte_valid = out_tuser;
      got.arg_index = out_tdata[10:8];
      got.arg_start = out_tdata[11];
      got.arg_end = out_tdata[12];
      got.line_done = out_tlast;
      got.arg_count = out_tdata[16:13];
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, data", 0, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.arg_byte != want.arg_byte)
          report_mismatch("arg_byte", want.arg_byte, got.arg_byte);
        if (got.byte_valid != want.byte_valid)
          report_mismatch("byte_valid", want.byte_valid, got.byte_valid);
        if (got.arg_index != want.arg_index)
          report_mismatch("arg_index", want.arg_index, got.arg_index);
        if (got.arg_start != want.arg_start)
          report_mismatch("arg_start", want.arg_start, got.arg_start);
        if (got.arg_end != want.arg_end)
          report_mismatch("arg_end", want.arg_end, got.arg_end);
        if (got.line_done != want.line_done)
          report_mismatch("line_done", want.line_done, got.line_done);
        if (got.arg_count != want.arg_count)
          report_mismatch("arg_count", want.arg_count, got.arg_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                 quiet, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    clear_line();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_quoted_lines();
    test_arg_limit();
    test_back_to_back();
    test_noise();
    wait_drained();
    $display("sent %0d bytes in %0d lines; %0d results checked, %0d mismatches",
             bytes_sent, lines_sent, results_seen, errors);
    $display("lines mixed quote groups, escapes, blanks, the argument limit and raw noise");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
